[rtl/selective_repeat_sender_window_top_assert.svh]
// assertion macros for the selective-repeat sender window
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_ASSERT_SVH

// same-cycle implication
`define SRSW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/srsw_pkg.sv]
`default_nettype none

package srsw_pkg;

   localparam int WINDOW_MAX_DEFAULT = 16;

   localparam int SEQ_W      = 16;
   localparam int CNT_W      = 32;
   localparam int KIND_W     = 2;
   localparam int WIN_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEND   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESEND = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TOTAL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET   = 5'd4;
   localparam logic [SEQ_W-1:0] FRAME_TOTAL_RESET   = 16'd1;
   localparam logic [SEQ_W-1:0] TIMEOUT_TICKS_RESET = 16'd3;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic slide;
      logic send;
      logic age;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tick_active;
      logic send_more;
      logic slide_more;
      logic range_empty;
      logic scan_acked;
      logic age_hit;
      logic scan_last;
      logic emit_ok;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/srsw_ctrl.sv]
`default_nettype none

module srsw_ctrl
   import srsw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SLIDE  = 3'd1;
   localparam logic [2:0] ST_SEND   = 3'd2;
   localparam logic [2:0] ST_AGE    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_ACK) begin
                  state_in = ST_SLIDE;
               end else if (status.tick_active) begin
                  state_in = ST_SEND;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SLIDE: begin
            if (status.slide_more) begin
               cmd.slide = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SEND: begin
            if (status.send_more) begin
               cmd.send = status.emit_ok;
            end else if (status.range_empty) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_AGE;
            end
         end
         ST_AGE: begin
            // a timeout needs room for the result, anything else just moves on
            if (status.scan_acked || !status.age_hit || status.emit_ok) begin
               cmd.age = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/srsw_datapath.sv]
`default_nettype none

module srsw_datapath
   import srsw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_op,
   input  logic [SEQ_W-1:0]      req_ack_seq,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [SEQ_W-1:0]      rsp_frame_seq,
   output logic                  rsp_last,
   output logic                  rsp_all_done,
   output logic [CNT_W-1:0]      rsp_sent_total,
   output logic [CNT_W-1:0]      rsp_resent_total
);

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);
   localparam logic [SLOT_W:0]   SLOT_SPAN = (SLOT_W + 1)'(WINDOW_MAX);
   localparam logic [SEQ_W:0]    WIN_CAP   = (SEQ_W + 1)'(WINDOW_MAX);

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_LAST) ? '0 : s + 1'b1;
   endfunction

   // configuration
   logic [WIN_W-1:0] win_ff, win_in;
   logic [SEQ_W-1:0] ft_ff, ft_in;
   logic [SEQ_W-1:0] tmo_ff, tmo_in;

   // window state
   logic [SEQ_W-1:0]      base_ff, base_in;
   logic [SEQ_W-1:0]      next_ff, next_in;
   logic [SLOT_W-1:0]     base_slot_ff, base_slot_in;
   logic [SLOT_W-1:0]     next_slot_ff, next_slot_in;
   logic [WINDOW_MAX-1:0] acked_ff, acked_in;
   logic [CNT_W-1:0]      sent_ff, sent_in;
   logic [CNT_W-1:0]      resent_ff, resent_in;

   // scan of outstanding frames during a tick
   logic [SEQ_W-1:0]  old_next_ff, old_next_in;
   logic [SEQ_W-1:0]  scan_ff, scan_in;
   logic [SLOT_W-1:0] scan_slot_ff, scan_slot_in;

   // timer store
   logic [SEQ_W-1:0]  timer_mem [WINDOW_MAX];
   logic [SEQ_W-1:0]  timer_rd_ff;
   logic [SLOT_W-1:0] timer_raddr;
   logic              timer_we;
   logic [SLOT_W-1:0] timer_waddr;
   logic [SEQ_W-1:0]  timer_wdata;

   // one result held back until it is known whether it closes the transaction
   logic              held_v_ff, held_v_in;
   logic [KIND_W-1:0] held_kind_ff, held_kind_in;
   logic [SEQ_W-1:0]  held_seq_ff, held_seq_in;
   logic [CNT_W-1:0]  held_sent_ff, held_sent_in;
   logic [CNT_W-1:0]  held_resent_ff, held_resent_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]  rsp_seq_ff, rsp_seq_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;
   logic [CNT_W-1:0]  rsp_sent_ff, rsp_sent_in;
   logic [CNT_W-1:0]  rsp_resent_ff, rsp_resent_in;

   logic [SEQ_W:0]    win_ext;
   logic [SEQ_W:0]    eff_win;
   logic [SEQ_W:0]    win_end;
   logic [SEQ_W-1:0]  tmo_eff;
   logic [SEQ_W-1:0]  timer_inc;
   logic [SEQ_W-1:0]  ack_diff;
   logic [SLOT_W:0]   ack_sum;
   logic [SLOT_W-1:0] ack_slot;
   logic              ack_hit;
   logic [CNT_W-1:0]  sent_next;
   logic [CNT_W-1:0]  resent_next;
   logic              out_free;
   logic              new_valid;
   logic [KIND_W-1:0] new_kind;
   logic [SEQ_W-1:0]  new_seq;

   assign win_ext   = (SEQ_W + 1)'(win_ff);
   assign eff_win   = (win_ff == '0) ? (SEQ_W + 1)'(1) :
                      ((win_ext > WIN_CAP) ? WIN_CAP : win_ext);
   assign win_end   = {1'b0, base_ff} + eff_win;
   assign tmo_eff   = (tmo_ff == '0) ? SEQ_W'(1) : tmo_ff;
   assign timer_inc = timer_rd_ff + 1'b1;

   // acked frame lies less than one window past base, so one wrap at most
   assign ack_diff = req_ack_seq - base_ff;
   assign ack_sum  = {1'b0, base_slot_ff} + {1'b0, ack_diff[SLOT_W-1:0]};
   assign ack_slot = (ack_sum >= SLOT_SPAN) ? SLOT_W'(ack_sum - SLOT_SPAN)
                                            : ack_sum[SLOT_W-1:0];
   assign ack_hit  = (req_op == OP_ACK) && (req_ack_seq >= base_ff)
                     && (req_ack_seq < next_ff);

   assign sent_next   = (sent_ff == '1) ? sent_ff : sent_ff + 1'b1;
   assign resent_next = (resent_ff == '1) ? resent_ff : resent_ff + 1'b1;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.tick_active = base_ff < ft_ff;
   assign status.send_more   = ({1'b0, next_ff} < win_end) && (next_ff < ft_ff);
   assign status.slide_more  = (base_ff != next_ff) && acked_ff[base_slot_ff];
   assign status.range_empty = (base_ff == old_next_ff);
   assign status.scan_acked  = acked_ff[scan_slot_ff];
   assign status.age_hit     = (timer_inc >= tmo_eff);
   assign status.scan_last   = ((scan_ff + 1'b1) == old_next_ff);
   assign status.emit_ok     = !held_v_ff || out_free;
   assign status.out_free    = out_free;

   assign timer_raddr = cmd.age ? slot_inc(scan_slot_ff) : scan_slot_ff;

   always_comb begin
      win_in         = win_ff;
      ft_in          = ft_ff;
      tmo_in         = tmo_ff;
      base_in        = base_ff;
      next_in        = next_ff;
      base_slot_in   = base_slot_ff;
      next_slot_in   = next_slot_ff;
      acked_in       = acked_ff;
      sent_in        = sent_ff;
      resent_in      = resent_ff;
      old_next_in    = old_next_ff;
      scan_in        = scan_ff;
      scan_slot_in   = scan_slot_ff;
      timer_we       = 1'b0;
      timer_waddr    = next_slot_ff;
      timer_wdata    = '0;
      new_valid      = 1'b0;
      new_kind       = KIND_STATUS;
      new_seq        = '0;
      held_v_in      = held_v_ff;
      held_kind_in   = held_kind_ff;
      held_seq_in    = held_seq_ff;
      held_sent_in   = held_sent_ff;
      held_resent_in = held_resent_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_sent_in    = rsp_sent_ff;
      rsp_resent_in  = rsp_resent_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:   win_in = csr_write_data[WIN_W-1:0];
            CSR_FRAME_TOTAL:   ft_in  = csr_write_data;
            CSR_TIMEOUT_TICKS: tmo_in = csr_write_data;
            default: begin
            end
         endcase
      end

      if (cmd.accept) begin
         old_next_in  = next_ff;
         scan_in      = base_ff;
         scan_slot_in = base_slot_ff;
         if (ack_hit) begin
            acked_in[ack_slot] = 1'b1;
         end
      end

      if (cmd.slide) begin
         base_in      = base_ff + 1'b1;
         base_slot_in = slot_inc(base_slot_ff);
      end

      if (cmd.send) begin
         acked_in[next_slot_ff] = 1'b0;
         timer_we     = 1'b1;
         timer_waddr  = next_slot_ff;
         timer_wdata  = '0;
         sent_in      = sent_next;
         next_in      = next_ff + 1'b1;
         next_slot_in = slot_inc(next_slot_ff);
         new_valid    = 1'b1;
         new_kind     = KIND_SEND;
         new_seq      = next_ff;
      end

      if (cmd.age) begin
         scan_in      = scan_ff + 1'b1;
         scan_slot_in = slot_inc(scan_slot_ff);
         if (!status.scan_acked) begin
            timer_we    = 1'b1;
            timer_waddr = scan_slot_ff;
            timer_wdata = status.age_hit ? '0 : timer_inc;
            if (status.age_hit) begin
               resent_in = resent_next;
               new_valid = 1'b1;
               new_kind  = KIND_RESEND;
               new_seq   = scan_ff;
            end
         end
      end

      if (new_valid) begin
         if (held_v_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = held_kind_ff;
            rsp_seq_in    = held_seq_ff;
            rsp_last_in   = 1'b0;
            rsp_done_in   = (base_ff >= ft_ff);
            rsp_sent_in   = held_sent_ff;
            rsp_resent_in = held_resent_ff;
         end
         held_v_in      = 1'b1;
         held_kind_in   = new_kind;
         held_seq_in    = new_seq;
         held_sent_in   = sent_in;
         held_resent_in = resent_in;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         rsp_done_in  = (base_ff >= ft_ff);
         if (held_v_ff) begin
            rsp_kind_in   = held_kind_ff;
            rsp_seq_in    = held_seq_ff;
            rsp_sent_in   = held_sent_ff;
            rsp_resent_in = held_resent_ff;
         end else begin
            rsp_kind_in   = KIND_STATUS;
            rsp_seq_in    = '0;
            rsp_sent_in   = sent_ff;
            rsp_resent_in = resent_ff;
         end
         held_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (timer_we) begin
         timer_mem[timer_waddr] <= timer_wdata;
      end
      timer_rd_ff <= timer_mem[timer_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WINDOW_SIZE_RESET;
         ft_ff        <= FRAME_TOTAL_RESET;
         tmo_ff       <= TIMEOUT_TICKS_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
         acked_ff     <= '0;
         sent_ff      <= '0;
         resent_ff    <= '0;
         held_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         ft_ff        <= ft_in;
         tmo_ff       <= tmo_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         acked_ff     <= acked_in;
         sent_ff      <= sent_in;
         resent_ff    <= resent_in;
         held_v_ff    <= held_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_next_ff    <= old_next_in;
      scan_ff        <= scan_in;
      scan_slot_ff   <= scan_slot_in;
      held_kind_ff   <= held_kind_in;
      held_seq_ff    <= held_seq_in;
      held_sent_ff   <= held_sent_in;
      held_resent_ff <= held_resent_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_sent_ff    <= rsp_sent_in;
      rsp_resent_ff  <= rsp_resent_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_frame_seq    = rsp_seq_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_all_done     = rsp_done_ff;
   assign rsp_sent_total   = rsp_sent_ff;
   assign rsp_resent_total = rsp_resent_ff;

endmodule

`default_nettype wire

[rtl/selective_repeat_sender_window_top.sv]
// channel  direction  handshake          payload
// req      in         req_valid/stall    req_op, req_ack_seq
// rsp      out        rsp_valid/stall    kind, frame_seq, last, all_done, sent/resent totals
// csr      in         csr_write_enable   csr_index, csr_write_data
//
// one transaction at a time; a tick sends new frames into the window, then walks the
// timer memory over outstanding frames one slot per cycle unless a timeout waits for room
// a tick once the base has reached the frame total goes straight to finish
// an ack marks its frame, then slides the base over the acked slots and finishes
// synchronous reset clears the window, counters and marks; the timer memory is not cleared
// rsp stall holds the result register; with a result held back and the register full, it pauses sends and timeouts

`default_nettype none

`include "selective_repeat_sender_window_top_assert.svh"

module selective_repeat_sender_window_top
   import srsw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [SEQ_W-1:0]      req_ack_seq,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [SEQ_W-1:0]      rsp_frame_seq,
   output logic                  rsp_last,
   output logic                  rsp_all_done,
   output logic [CNT_W-1:0]      rsp_sent_total,
   output logic [CNT_W-1:0]      rsp_resent_total,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;
   logic [4:0] cmd_bits;

   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srsw_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_ack_seq      (req_ack_seq),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_frame_seq    (rsp_frame_seq),
      .rsp_last         (rsp_last),
      .rsp_all_done     (rsp_all_done),
      .rsp_sent_total   (rsp_sent_total),
      .rsp_resent_total (rsp_resent_total)
   );

   assign cmd_bits = {cmd.accept, cmd.slide, cmd.send, cmd.age, cmd.finish};

   `SRSW_ASSERT_NOW(a_single_cmd, clock, reset, 1'b1, $onehot0(cmd_bits), "more than one command")
   `SRSW_ASSERT_NOW(a_finish_room, clock, reset, cmd.finish, status.out_free, "finish while full")
   `SRSW_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall, "accept not held")
   `SRSW_ASSERT_NEXT(a_last, clock, reset, cmd.finish, rsp_valid && rsp_last, "last missing")

endmodule

`default_nettype wire
